// ===== hdl/tbo_pkg.sv =====
// Package for the triangle/box overlap pipeline: widths, register codes, index tables.
`default_nettype none
package tbo_pkg;

  // Coordinate width (signed Q12.12)
  localparam int CW    = 24;
  // Doubled, centered vertex coordinate
  localparam int DW    = CW + 2;
  // Doubled half size of the box
  localparam int HW    = CW + 1;
  // Edge component
  localparam int EW    = CW + 3;
  // Edge component times coordinate, and the projection difference
  localparam int PMW   = EW + DW;
  localparam int PW    = PMW + 1;
  // Radius products and their sum
  localparam int RPW   = EW + 1 + HW;
  localparam int RW    = RPW + 1;
  // Compare width for projection against radius
  localparam int XW    = PW + 1;
  // Normal component products and the normal
  localparam int NPW   = 2 * EW;
  localparam int NW    = NPW + 1;
  // Box corner relative to vertex 0
  localparam int VW    = CW + 3;
  // Split of the normal for the plane products
  localparam int NLW   = NW / 2;
  localparam int NHW   = NW - NLW;
  localparam int MLW   = NLW + 1 + VW;
  localparam int MHW   = NHW + VW;
  // Full plane product and the sum of three
  localparam int SW    = NW + VW + 2;

  // Pipeline depth, output register included
  localparam int NST   = 8;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MAX_Z = 3'd5;

  // Cyclic successor and predecessor of an axis or vertex index
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [DW-1:0]  dcoord_t;
  typedef logic signed [HW-1:0]  half_t;
  typedef logic signed [EW-1:0]  edge_t;
  typedef logic signed [PMW-1:0] pmul_t;
  typedef logic signed [PW-1:0]  proj_t;
  typedef logic signed [RPW-1:0] rmul_t;
  typedef logic signed [RW-1:0]  rad_t;
  typedef logic signed [XW-1:0]  cmp_t;
  typedef logic signed [NPW-1:0] nmul_t;
  typedef logic signed [NW-1:0]  norm_t;
  typedef logic signed [VW-1:0]  vcorner_t;
  typedef logic signed [MLW-1:0] mlo_t;
  typedef logic signed [MHW-1:0] mhi_t;
  typedef logic signed [SW-1:0]  sum_t;

endpackage
`default_nettype wire

// ===== hdl/triangle_box_overlap_test.sv =====
// Top level: pipelined separating-axis overlap test of a triangle against a box.
//
// Usage: the box corners sit in six registers written through cfg_we_i /
// cfg_idx_i / cfg_data_i (0..2 lower corner x,y,z, 3..5 upper corner x,y,z;
// other indexes are ignored). Write them only while the pipeline is empty.
// A triangle item is taken on the input channel when in_valid_i is high and
// in_stall_o is low; one flag comes back on the output channel, taken when
// out_valid_o is high and out_stall_i is low. overlaps_o is 1 when the
// triangle touches or intersects the box.
// out_valid_o rises once the item reaches the output register, and a new
// item is taken every cycle while in_stall_o is low.
// The depth is set by the multiplier stages: edge products,
// their sums, normal split products, product recombine and the final sums.
// Every stage holds its item while the next one cannot load, so bubbles are
// squeezed out; in_stall_o rises only when all eight stages hold items and
// the receiver stalls. Reset empties the pipeline and clears the box
// registers to zero; results already in flight are dropped.
`default_nettype none
module triangle_box_overlap_test (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [tbo_pkg::CFG_IW-1:0]      cfg_idx_i,
  input  wire [tbo_pkg::CW-1:0]          cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire signed [tbo_pkg::CW-1:0]   vert0_x_i,
  input  wire signed [tbo_pkg::CW-1:0]   vert0_y_i,
  input  wire signed [tbo_pkg::CW-1:0]   vert0_z_i,
  input  wire signed [tbo_pkg::CW-1:0]   vert1_x_i,
  input  wire signed [tbo_pkg::CW-1:0]   vert1_y_i,
  input  wire signed [tbo_pkg::CW-1:0]   vert1_z_i,
  input  wire signed [tbo_pkg::CW-1:0]   vert2_x_i,
  input  wire signed [tbo_pkg::CW-1:0]   vert2_y_i,
  input  wire signed [tbo_pkg::CW-1:0]   vert2_z_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           overlaps_o
);

  // Box registers
  tbo_pkg::coord_t box_min_q [3];
  tbo_pkg::coord_t box_max_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        box_min_q[k] <= '0;
        box_max_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbo_pkg::REG_MIN_X: box_min_q[0] <= cfg_data_i;
        tbo_pkg::REG_MIN_Y: box_min_q[1] <= cfg_data_i;
        tbo_pkg::REG_MIN_Z: box_min_q[2] <= cfg_data_i;
        tbo_pkg::REG_MAX_X: box_max_q[0] <= cfg_data_i;
        tbo_pkg::REG_MAX_Y: box_max_q[1] <= cfg_data_i;
        tbo_pkg::REG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valids and load enables; a stage loads when empty or when the next one loads
  logic [tbo_pkg::NST-1:0] vld_q;
  logic [tbo_pkg::NST-1:0] ld;

  always_comb begin
    ld[tbo_pkg::NST-1] = !vld_q[tbo_pkg::NST-1] || !out_stall_i;
    for (int k = tbo_pkg::NST - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < tbo_pkg::NST; k++) begin
        if (ld[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = vld_q[tbo_pkg::NST-1];

  // Vertex fields as [vertex][axis]
  tbo_pkg::coord_t vin [3][3];
  assign vin[0][0] = vert0_x_i;
  assign vin[0][1] = vert0_y_i;
  assign vin[0][2] = vert0_z_i;
  assign vin[1][0] = vert1_x_i;
  assign vin[1][1] = vert1_y_i;
  assign vin[1][2] = vert1_z_i;
  assign vin[2][0] = vert2_x_i;
  assign vin[2][1] = vert2_y_i;
  assign vin[2][2] = vert2_z_i;

  // ---------------- Stage 1: doubled centered coordinates, doubled half size
  tbo_pkg::dcoord_t d1_d [3][3], d1_q [3][3];  // [axis][vertex]
  tbo_pkg::half_t   h1_d [3],    h1_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h1_d[k] = tbo_pkg::HW'(box_max_q[k]) - tbo_pkg::HW'(box_min_q[k]);
      for (int i = 0; i < 3; i++) begin
        d1_d[k][i] = (tbo_pkg::DW'(vin[i][k]) <<< 1) - tbo_pkg::DW'(box_min_q[k])
                     - tbo_pkg::DW'(box_max_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      d1_q <= d1_d;
      h1_q <= h1_d;
    end
  end

  // ---------------- Stage 2: edges and box-face test
  tbo_pkg::edge_t   e2_d [3][3], e2_q [3][3];  // [edge][axis]
  tbo_pkg::dcoord_t d2_q [3][3];
  tbo_pkg::half_t   h2_q [3];
  logic             face2_d, face2_q;

  always_comb begin
    tbo_pkg::dcoord_t hx, nhx;
    logic above, below;
    face2_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        e2_d[i][k] = tbo_pkg::EW'(d1_q[k][tbo_pkg::NXT[i]]) - tbo_pkg::EW'(d1_q[k][i]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      hx    = tbo_pkg::DW'(h1_q[k]);
      nhx   = -hx;
      above = (d1_q[k][0] > hx) && (d1_q[k][1] > hx) && (d1_q[k][2] > hx);
      below = (d1_q[k][0] < nhx) && (d1_q[k][1] < nhx) && (d1_q[k][2] < nhx);
      if (above || below) face2_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      e2_q    <= e2_d;
      d2_q    <= d1_q;
      h2_q    <= h1_q;
      face2_q <= face2_d;
    end
  end

  // ---------------- Stage 3: edge-axis products, normal products, plane corners
  tbo_pkg::pmul_t   pa3_d [3][3][3], pa3_q [3][3][3];  // [edge][axis][vertex]
  tbo_pkg::pmul_t   qb3_d [3][3][3], qb3_q [3][3][3];
  tbo_pkg::rmul_t   ra3_d [3][3],    ra3_q [3][3];
  tbo_pkg::rmul_t   rb3_d [3][3],    rb3_q [3][3];
  tbo_pkg::nmul_t   np3_d [3],       np3_q [3];
  tbo_pkg::nmul_t   nm3_d [3],       nm3_q [3];
  tbo_pkg::vcorner_t va3_d [3],      va3_q [3];
  tbo_pkg::vcorner_t vb3_d [3],      vb3_q [3];
  logic             face3_q;

  always_comb begin
    tbo_pkg::edge_t ea, eb;
    logic signed [tbo_pkg::EW:0] aa, ab;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // axis j of edge i: a = e[prev j], b = e[next j], P = d[next j], Q = d[prev j]
        ea = e2_q[i][tbo_pkg::PRV[j]];
        eb = e2_q[i][tbo_pkg::NXT[j]];
        aa = ea[tbo_pkg::EW-1] ? -(tbo_pkg::EW+1)'(ea) : (tbo_pkg::EW+1)'(ea);
        ab = eb[tbo_pkg::EW-1] ? -(tbo_pkg::EW+1)'(eb) : (tbo_pkg::EW+1)'(eb);
        ra3_d[i][j] = aa * h2_q[tbo_pkg::NXT[j]];
        rb3_d[i][j] = ab * h2_q[tbo_pkg::PRV[j]];
        for (int v = 0; v < 3; v++) begin
          pa3_d[i][j][v] = ea * d2_q[tbo_pkg::NXT[j]][v];
          qb3_d[i][j][v] = eb * d2_q[tbo_pkg::PRV[j]][v];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      np3_d[k] = e2_q[0][tbo_pkg::NXT[k]] * e2_q[1][tbo_pkg::PRV[k]];
      nm3_d[k] = e2_q[0][tbo_pkg::PRV[k]] * e2_q[1][tbo_pkg::NXT[k]];
      va3_d[k] = -tbo_pkg::VW'(h2_q[k]) - tbo_pkg::VW'(d2_q[k][0]);
      vb3_d[k] = tbo_pkg::VW'(h2_q[k]) - tbo_pkg::VW'(d2_q[k][0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      pa3_q   <= pa3_d;
      qb3_q   <= qb3_d;
      ra3_q   <= ra3_d;
      rb3_q   <= rb3_d;
      np3_q   <= np3_d;
      nm3_q   <= nm3_d;
      va3_q   <= va3_d;
      vb3_q   <= vb3_d;
      face3_q <= face2_q;
    end
  end

  // ---------------- Stage 4: projections, radii, normal
  tbo_pkg::proj_t    p4_d [3][3][3], p4_q [3][3][3];
  tbo_pkg::rad_t     r4_d [3][3],    r4_q [3][3];
  tbo_pkg::norm_t    n4_d [3],       n4_q [3];
  tbo_pkg::vcorner_t va4_q [3], vb4_q [3];
  logic              face4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r4_d[i][j] = tbo_pkg::RW'(ra3_q[i][j]) + tbo_pkg::RW'(rb3_q[i][j]);
        for (int v = 0; v < 3; v++) begin
          p4_d[i][j][v] = tbo_pkg::PW'(pa3_q[i][j][v]) - tbo_pkg::PW'(qb3_q[i][j][v]);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      n4_d[k] = tbo_pkg::NW'(np3_q[k]) - tbo_pkg::NW'(nm3_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      p4_q    <= p4_d;
      r4_q    <= r4_d;
      n4_q    <= n4_d;
      va4_q   <= va3_q;
      vb4_q   <= vb3_q;
      face4_q <= face3_q;
    end
  end

  // ---------------- Stage 5: edge-axis compares, split plane products
  logic           ok5_d, ok5_q;
  tbo_pkg::mlo_t  mnl5_d [3], mnl5_q [3], mxl5_d [3], mxl5_q [3];
  tbo_pkg::mhi_t  mnh5_d [3], mnh5_q [3], mxh5_d [3], mxh5_q [3];

  always_comb begin
    tbo_pkg::cmp_t rx, nrx;
    logic above, below, npos;
    tbo_pkg::vcorner_t vmn, vmx;
    logic signed [tbo_pkg::NLW:0]   nlo;
    logic signed [tbo_pkg::NHW-1:0] nhi;
    ok5_d = face4_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rx    = tbo_pkg::XW'(r4_q[i][j]);
        nrx   = -rx;
        above = (tbo_pkg::XW'(p4_q[i][j][0]) > rx) && (tbo_pkg::XW'(p4_q[i][j][1]) > rx)
                && (tbo_pkg::XW'(p4_q[i][j][2]) > rx);
        below = (tbo_pkg::XW'(p4_q[i][j][0]) < nrx) && (tbo_pkg::XW'(p4_q[i][j][1]) < nrx)
                && (tbo_pkg::XW'(p4_q[i][j][2]) < nrx);
        if (above || below) ok5_d = 1'b0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      npos = !n4_q[k][tbo_pkg::NW-1] && (n4_q[k] != '0);
      vmn  = npos ? va4_q[k] : vb4_q[k];
      vmx  = npos ? vb4_q[k] : va4_q[k];
      nlo  = $signed({1'b0, n4_q[k][tbo_pkg::NLW-1:0]});
      nhi  = $signed(n4_q[k][tbo_pkg::NW-1:tbo_pkg::NLW]);
      mnl5_d[k] = nlo * vmn;
      mxl5_d[k] = nlo * vmx;
      mnh5_d[k] = nhi * vmn;
      mxh5_d[k] = nhi * vmx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      ok5_q  <= ok5_d;
      mnl5_q <= mnl5_d;
      mxl5_q <= mxl5_d;
      mnh5_q <= mnh5_d;
      mxh5_q <= mxh5_d;
    end
  end

  // ---------------- Stage 6: recombine split products
  tbo_pkg::sum_t pmn6_d [3], pmn6_q [3], pmx6_d [3], pmx6_q [3];
  logic          ok6_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pmn6_d[k] = (tbo_pkg::SW'(mnh5_q[k]) <<< tbo_pkg::NLW) + tbo_pkg::SW'(mnl5_q[k]);
      pmx6_d[k] = (tbo_pkg::SW'(mxh5_q[k]) <<< tbo_pkg::NLW) + tbo_pkg::SW'(mxl5_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      pmn6_q <= pmn6_d;
      pmx6_q <= pmx6_d;
      ok6_q  <= ok5_q;
    end
  end

  // ---------------- Stage 7: plane distances of the nearest and farthest corners
  tbo_pkg::sum_t dmn7_q, dmx7_q;
  logic          ok7_q;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      dmn7_q <= pmn6_q[0] + pmn6_q[1] + pmn6_q[2];
      dmx7_q <= pmx6_q[0] + pmx6_q[1] + pmx6_q[2];
      ok7_q  <= ok6_q;
    end
  end

  // ---------------- Stage 8: plane test and output register
  logic overlaps_d, overlaps_q;

  always_comb begin
    overlaps_d = ok7_q;
    if (!dmn7_q[tbo_pkg::SW-1] && (dmn7_q != '0)) overlaps_d = 1'b0;
    if (dmx7_q[tbo_pkg::SW-1]) overlaps_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) overlaps_q <= overlaps_d;
  end

  assign overlaps_o = overlaps_q;

endmodule
`default_nettype wire

// ===== hdl/tbo_checker.sv =====
// Port-level checks of the overlap pipeline, bound to the top level.
`default_nettype none
module tbo_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_stall_o,
  input wire out_valid_o,
  input wire out_stall_i,
  input wire overlaps_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(overlaps_o))
    else $error("result changed while stalled");

  // Input only stalls when the output side is full and held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled with room in the pipeline");

  // Reset empties the pipeline
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

  // No result is offered right after reset is released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind triangle_box_overlap_test tbo_checker u_tbo_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the triangle/box overlap pipeline.
`default_nettype none
module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tbo_pkg::CFG_IW-1:0] cfg_idx_i = '0;
  logic [tbo_pkg::CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tbo_pkg::coord_t vx_q [9];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic overlaps_o;

  // Predictor's copy of the box registers
  tbo_pkg::coord_t box_q [6];
  bit overlap_flags_q [$];
  bit failed = 1'b0;
  // Receiver wait left before it takes the next item
  int unsigned rx_wait = 0;

  initial for (int i = 0; i < 9; i++) vx_q[i] = '0;

  triangle_box_overlap_test dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .vert0_x_i(vx_q[0]), .vert0_y_i(vx_q[1]), .vert0_z_i(vx_q[2]),
    .vert1_x_i(vx_q[3]), .vert1_y_i(vx_q[4]), .vert1_z_i(vx_q[5]),
    .vert2_x_i(vx_q[6]), .vert2_y_i(vx_q[7]), .vert2_z_i(vx_q[8]),
    .out_valid_o, .out_stall_i, .overlaps_o
  );

  initial forever #2 clk_i = ~clk_i;

  // Fail-safe run limit
  initial begin
    #4000000;
    $display("triangle_box_overlap_test regression: fail");
    $finish;
  end

  typedef logic signed [127:0] wide_t;

  // True when axis (a,b) separates: a*P - b*Q against |a|hP + |b|hQ
  function automatic bit axis_separates(wide_t a, wide_t b, wide_t p [3], wide_t q [3],
                                        wide_t hp, wide_t hq);
    wide_t rad, pr, lo, hi;
    rad = (a < 0 ? -a : a) * hp + (b < 0 ? -b : b) * hq;
    for (int i = 0; i < 3; i++) begin
      pr = a * p[i] - b * q[i];
      if (i == 0 || pr < lo) lo = pr;
      if (i == 0 || pr > hi) hi = pr;
    end
    return lo > rad || hi < -rad;
  endfunction

  // Exact separating-axis overlap on doubled, box-centered coordinates
  function automatic bit tri_box_overlap(tbo_pkg::coord_t v [9]);
    wide_t h [3], n [3];
    wide_t d [3][3], e [3][3];
    wide_t lo, hi, mn, mx, dmn, dmx, a, b;
    bit hit;
    hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      h[k] = wide_t'(box_q[k+3]) - wide_t'(box_q[k]);
      for (int i = 0; i < 3; i++)
        d[k][i] = 2 * wide_t'(v[i*3+k]) - wide_t'(box_q[k]) - wide_t'(box_q[k+3]);
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) e[i][k] = d[k][(i+1)%3] - d[k][i];
    for (int i = 0; i < 3; i++)
      if (axis_separates(e[i][2], e[i][1], d[1], d[2], h[1], h[2]) ||
          axis_separates(e[i][0], e[i][2], d[2], d[0], h[2], h[0]) ||
          axis_separates(e[i][1], e[i][0], d[0], d[1], h[0], h[1])) hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo = d[k][0]; hi = d[k][0];
      for (int i = 1; i < 3; i++) begin
        if (d[k][i] < lo) lo = d[k][i];
        if (d[k][i] > hi) hi = d[k][i];
      end
      if (lo > h[k] || hi < -h[k]) hit = 1'b0;
    end
    if (hit) begin
      n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
      n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
      n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
      dmn = 0; dmx = 0;
      for (int k = 0; k < 3; k++) begin
        a = -h[k] - d[k][0];
        b = h[k] - d[k][0];
        if (n[k] > 0) begin mn = a; mx = b; end
        else begin mn = b; mx = a; end
        dmn += n[k] * mn;
        dmx += n[k] * mx;
      end
      if (dmn > 0 || dmx < 0) hit = 1'b0;
    end
    return hit;
  endfunction

  // Write one box register (pipeline must be empty)
  task automatic write_box(logic [tbo_pkg::CFG_IW-1:0] idx, tbo_pkg::coord_t val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx < 6) box_q[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_box(tbo_pkg::coord_t mn [3], tbo_pkg::coord_t mx [3]);
    write_box(tbo_pkg::REG_MIN_X, mn[0]); write_box(tbo_pkg::REG_MIN_Y, mn[1]);
    write_box(tbo_pkg::REG_MIN_Z, mn[2]); write_box(tbo_pkg::REG_MAX_X, mx[0]);
    write_box(tbo_pkg::REG_MAX_Y, mx[1]); write_box(tbo_pkg::REG_MAX_Z, mx[2]);
  endtask

  task automatic drain();
    while (overlap_flags_q.size() != 0) @(posedge clk_i);
    repeat (tbo_pkg::NST + 4) @(posedge clk_i);
  endtask

  // Send one triangle, random idle cycles first
  task automatic send_triangle(tbo_pkg::coord_t v [9]);
    repeat ($urandom_range(0, 10) * ($urandom_range(0, 3) != 0)) @(posedge clk_i);
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) vx_q[i] <= v[i];
    overlap_flags_q.push_back(tri_box_overlap(v));
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 1'b0;
  endtask

  // Result checker; the receiver waits a random count of cycles per item
  always @(posedge clk_i) begin
    bit exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (overlap_flags_q.size() == 0) begin
        $error("unexpected item: overlaps=%0b", overlaps_o);
        failed = 1'b1;
      end else begin
        exp = overlap_flags_q.pop_front();
        if (overlaps_o !== exp) begin
          $error("overlaps mismatch: expected %0b actual %0b", exp, overlaps_o);
          failed = 1'b1;
        end
      end
      rx_wait = $urandom_range(0, 10);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait != 0);
  end

  function automatic tbo_pkg::coord_t rnd_coord(int span);
    if (span == 0) return tbo_pkg::coord_t'($urandom());
    return tbo_pkg::coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  // Random triangle: coordinates within +-span around zero, full range when span is 0
  task automatic rnd_triangle(int span);
    tbo_pkg::coord_t v [9];
    for (int i = 0; i < 9; i++) v[i] = rnd_coord(span);
    send_triangle(v);
  endtask

  task automatic test_directed();
    tbo_pkg::coord_t mn [3] = '{-4096, -4096, -4096};
    tbo_pkg::coord_t mx [3] = '{4096, 4096, 4096};
    tbo_pkg::coord_t v [9];
    set_box(mn, mx);
    // inside, touching face, far away, degenerate, straddling
    v = '{0, 0, 0, 100, 0, 0, 0, 100, 0}; send_triangle(v);
    v = '{4096, 0, 0, 4096, 10, 0, 4096, 0, 10}; send_triangle(v);
    v = '{4097, 0, 0, 4097, 10, 0, 4097, 0, 10}; send_triangle(v);
    v = '{9000, 9000, 9000, 9000, 9000, 9000, 9000, 9000, 9000}; send_triangle(v);
    v = '{-9000, 0, 0, 9000, 0, 0, 0, 0, 0}; send_triangle(v);
    v = '{-20000, -20000, 0, 20000, -20000, 0, 0, 20000, 0}; send_triangle(v);
    v = '{-20000, 0, 9000, 20000, 0, 9000, 0, 20000, 9000}; send_triangle(v);
    v = '{10000, 0, 0, 0, 10000, 0, 0, 0, 10000}; send_triangle(v);
    v = '{6000, 0, 0, 0, 6000, 0, 0, 0, 6000}; send_triangle(v);
    // field extremes
    for (int i = 0; i < 9; i++) v[i] = 24'h800000; send_triangle(v);
    for (int i = 0; i < 9; i++) v[i] = 24'h7FFFFF; send_triangle(v);
    v = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
          24'h7FFFFF, 24'h800000, 24'h7FFFFF};
    send_triangle(v);
    drain();
    // extreme and inverted boxes
    mn = '{24'h800000, 24'h800000, 24'h800000}; mx = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
    set_box(mn, mx);
    v = '{24'h800000, 24'h7FFFFF, 0, 24'h7FFFFF, 24'h800000, 0, 0, 0, 24'h7FFFFF};
    send_triangle(v);
    rnd_triangle(0); rnd_triangle(0);
    drain();
    mn = '{4096, 0, 0}; mx = '{-4096, 100, 100};
    set_box(mn, mx);
    v = '{0, 50, 50, 10, 50, 50, 0, 60, 50}; send_triangle(v);
    rnd_triangle(200); rnd_triangle(8000);
    drain();
    write_box(3'd6, 24'h123456);
    write_box(3'd7, 24'hABCDEF);
    rnd_triangle(8000);
    drain();
  endtask

  // Random boxes; phases 0,3,6 full-range, else mostly small triangles near the box
  task automatic test_random();
    tbo_pkg::coord_t mn [3], mx [3];
    int span;
    for (int phase = 0; phase < 9; phase++) begin
      span = (phase % 3 == 0) ? 0 : 20000;
      for (int k = 0; k < 3; k++) begin
        mn[k] = rnd_coord(span == 0 ? 0 : 8000);
        mx[k] = (phase == 4) ? rnd_coord(8000)
                             : tbo_pkg::coord_t'(mn[k] + $urandom_range(0, 12000));
        if (span == 0) mx[k] = rnd_coord(0);
      end
      set_box(mn, mx);
      for (int j = 0; j < 44; j++) rnd_triangle($urandom_range(0, 7) == 0 ? 0 : span);
      drain();
    end
  endtask

  // Back-to-back burst against receiver stalls
  task automatic test_burst();
    tbo_pkg::coord_t v [9];
    for (int j = 0; j < 20; j++) begin
      @(posedge clk_i);
      in_valid_i <= 1'b1;
      for (int i = 0; i < 9; i++) v[i] = rnd_coord(12000);
      for (int i = 0; i < 9; i++) vx_q[i] <= v[i];
      overlap_flags_q.push_back(tri_box_overlap(v));
      do @(posedge clk_i); while (in_stall_o);
      if (j == 19) in_valid_i <= 1'b0;
      else begin
        for (int i = 0; i < 9; i++) v[i] = rnd_coord(12000);
        for (int i = 0; i < 9; i++) vx_q[i] <= v[i];
        overlap_flags_q.push_back(tri_box_overlap(v));
        while (1) begin
          @(posedge clk_i);
          if (!in_stall_o) break;
        end
        in_valid_i <= 1'b0;
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 6; i++) box_q[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    test_burst();
    if (!failed && overlap_flags_q.size() == 0)
      $display("triangle_box_overlap_test regression: pass");
    else
      $display("triangle_box_overlap_test regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
